FILE: hdl/source_character_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// Source character tokenizer assertion macros
// Shorthand for clocked concurrent assertions used across the block.
// ----------------------------------------------------------------------------
`ifndef SOURCE_CHARACTER_TOKENIZER_MACROS_SVH
`define SOURCE_CHARACTER_TOKENIZER_MACROS_SVH

// Check a property on every rising edge of clk, ignored while rst is high.
`define SCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge of clk, including reset cycles.
`define SCT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/sct_pkg.sv
// ----------------------------------------------------------------------------
// Source character tokenizer package
// Shared types, limits, character codes and classification functions.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int POS_W  = 16;
  localparam int LEN_W  = 12;
  localparam int KIND_W = 5;
  localparam int PREFIX_W = 48;
  localparam int PREFIX_BYTES = PREFIX_W / 8;

  localparam logic [POS_W-1:0] POSITION_LIMIT = 16'd65535;
  localparam logic [LEN_W-1:0] LENGTH_LIMIT   = 12'd4095;

  localparam int MAX_RESULTS = 3;
  localparam int NUM_W       = 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = 2;
  localparam int CNT_W       = 3;

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_DIGIT9  = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  // Keyword spellings, packed first byte high
  localparam logic [PREFIX_W-1:0] WORD_DEF    = 48'h0000_0064_6566;
  localparam logic [PREFIX_W-1:0] WORD_FN     = 48'h0000_0000_666E;
  localparam logic [PREFIX_W-1:0] WORD_MODULE = 48'h6D6F_6475_6C65;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER,
    MODE_LINE,
    MODE_BLOCK
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDENT, KIND_DEF, KIND_FN, KIND_MODULE, KIND_COLON, KIND_ASSIGN,
    KIND_ARROW, KIND_LPAREN, KIND_RPAREN, KIND_SEMI, KIND_LBRACE, KIND_RBRACE,
    KIND_INT, KIND_PLUS, KIND_MINUS, KIND_SLASH, KIND_STAR, KIND_CARET,
    KIND_COMMA, KIND_END, KIND_BAD, KIND_UNCLOSED
  } kind_t;

  typedef struct packed {
    mode_t                mode;
    logic                 pending_equals;
    logic                 pending_hash;
    logic                 saw_close_paren;
    logic                 stopped;
    logic [POS_W-1:0]     current_line;
    logic [POS_W-1:0]     current_column;
    logic [POS_W-1:0]     token_line;
    logic [POS_W-1:0]     token_column;
    logic [LEN_W-1:0]     token_count;
    logic [PREFIX_W-1:0]  word_prefix;
  } lex_state_t;

  localparam lex_state_t STATE_RESET = '{
    mode:            MODE_IDLE,
    pending_equals:  1'b0,
    pending_hash:    1'b0,
    saw_close_paren: 1'b0,
    stopped:         1'b0,
    current_line:    16'd1,
    current_column:  16'd1,
    token_line:      16'd1,
    token_column:    16'd1,
    token_count:     12'd0,
    word_prefix:     48'd0
  };

  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
    logic [LEN_W-1:0] length;
    logic             last;
  } token_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b == CH_UNDER) || (b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
           (b >= CH_UPPER_A && b <= CH_UPPER_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_DIGIT0) && (b <= CH_DIGIT9);
  endfunction

  // Kind of a one-character operator; anything else maps to bad char
  function automatic kind_t single_kind(input logic [7:0] b);
    kind_t k;
    unique case (b)
      CH_COLON:  k = KIND_COLON;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_SEMI:   k = KIND_SEMI;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_SLASH:  k = KIND_SLASH;
      CH_STAR:   k = KIND_STAR;
      CH_CARET:  k = KIND_CARET;
      CH_COMMA:  k = KIND_COMMA;
      default:   k = KIND_BAD;
    endcase
    return k;
  endfunction

  function automatic logic [POS_W-1:0] sat_inc_pos(input logic [POS_W-1:0] p);
    return (p < POSITION_LIMIT) ? POS_W'(p + 1'b1) : p;
  endfunction

  function automatic token_t make_token(input kind_t k, input logic [POS_W-1:0] line,
                                        input logic [POS_W-1:0] column,
                                        input logic [LEN_W-1:0] length);
    token_t t;
    t.kind   = k;
    t.line   = line;
    t.column = column;
    t.length = length;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

FILE: hdl/sct_if.sv
// ----------------------------------------------------------------------------
// Source character tokenizer channels
// Valid/ready channels for source bytes in and tokens out.
// ----------------------------------------------------------------------------
interface sct_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;

  modport source (output valid, output source_byte, output end_of_source, input ready);
  modport sink   (input valid, input source_byte, input end_of_source, output ready);
endinterface

interface sct_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [11:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_line, output start_column,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input start_line, input start_column,
                  input token_length, input last_of_run, output ready);
endinterface

FILE: hdl/source_character_tokenizer.sv
// ----------------------------------------------------------------------------
// Source character tokenizer
// Byte-in, token-out lexer with saturating line and column tracking.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle on chars while the token queue has room and
// delivers tokens on tokens, each with kind, start line, start column and
// length; last_of_run flags the final token caused by a byte. A byte is held
// in an input register, decoded in one pass, and its zero to three tokens are
// written together into a four-word token queue. The next byte is decoded as
// soon as at most one token waits in that queue, so a stream that yields no
// more than one token per byte runs at one byte per cycle while the token
// side keeps up; a byte that yields two or three tokens holds the following
// byte while the queue drains. After an end, bad char or unclosed comment
// token, bytes are taken and dropped until the one marked end_of_source,
// which returns the lexer to its reset state for the next stream.
`include "source_character_tokenizer_macros.svh"

module source_character_tokenizer
  import sct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sct_byte_if.sink    chars,
  sct_token_if.source tokens
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             held_eos;
  lex_state_t       state;
  lex_state_t       state_next;
  token_t           step_toks [MAX_RESULTS];
  logic [NUM_W-1:0] step_num;
  logic [NUM_W-1:0] push_num;
  logic             room;
  logic             fire;

  assign fire        = held_valid && room;
  assign chars.ready = !held_valid || fire;
  assign push_num    = fire ? step_num : '0;

  // Hold the incoming byte
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (chars.ready) begin
      held_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      held_byte <= chars.source_byte;
      held_eos  <= chars.end_of_source;
    end
  end

  // Advance the lexer state when the held byte is decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  sct_step u_step (
    .state         (state),
    .source_byte   (held_byte),
    .end_of_source (held_eos),
    .state_next    (state_next),
    .toks          (step_toks),
    .num_toks      (step_num)
  );

  sct_token_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_toks (step_toks),
    .push_num  (push_num),
    .room      (room),
    .tokens    (tokens)
  );

  `SCT_ASSERT(a_end_resets_state, (fire && held_eos) |=> (state == STATE_RESET), "state not cleared after end of source")
  `SCT_ASSERT(a_stall_needs_byte, !chars.ready |-> (held_valid && !room), "input stalled without a held byte")

endmodule

FILE: hdl/sct_step.sv
// ----------------------------------------------------------------------------
// Source character tokenizer step
// Next lexer state and up to three tokens for one held source byte.
// ----------------------------------------------------------------------------
module sct_step
  import sct_pkg::*;
(
  input  lex_state_t       state,
  input  logic [7:0]       source_byte,
  input  logic             end_of_source,
  output lex_state_t       state_next,
  output token_t           toks [MAX_RESULTS],
  output logic [NUM_W-1:0] num_toks
);

  always_comb begin
    lex_state_t       s;
    token_t           t [MAX_RESULTS];
    logic [NUM_W-1:0] n;
    logic             handled;
    logic             more;
    kind_t            wk;
    logic [7:0]       b;

    s       = state;
    n       = '0;
    handled = 1'b0;
    more    = 1'b0;
    wk      = KIND_IDENT;
    b       = source_byte;
    for (int i = 0; i < MAX_RESULTS; i++) t[i] = '0;

    // Word kind from the held prefix and length
    if (state.mode == MODE_NUMBER) begin
      wk = KIND_INT;
    end else if (state.token_count == 12'd3 && state.word_prefix == WORD_DEF) begin
      wk = KIND_DEF;
    end else if (state.token_count == 12'd2 && state.word_prefix == WORD_FN) begin
      wk = KIND_FN;
    end else if (state.token_count == 12'd6 && state.word_prefix == WORD_MODULE) begin
      wk = KIND_MODULE;
    end

    if (state.stopped) begin
      // drop bytes until the end of the stream
      if (end_of_source) s = STATE_RESET;
    end else begin
      // resolve a held '='
      if (s.pending_equals) begin
        s.pending_equals = 1'b0;
        if (b == CH_GREATER) begin
          t[n] = make_token(KIND_ARROW, s.token_line, s.token_column, 12'd2);
          n = NUM_W'(n + 1'b1);
          s.current_column = sat_inc_pos(s.current_column);
          handled = 1'b1;
        end else begin
          t[n] = make_token(KIND_ASSIGN, s.token_line, s.token_column, 12'd1);
          n = NUM_W'(n + 1'b1);
        end
      end

      // resolve a held '#'
      if (s.pending_hash) begin
        s.pending_hash    = 1'b0;
        s.mode            = (b == CH_LPAREN) ? MODE_BLOCK : MODE_LINE;
        s.saw_close_paren = 1'b0;
      end

      // extend or close a word or number
      if (!handled && (s.mode == MODE_WORD || s.mode == MODE_NUMBER)) begin
        more = is_digit(b) || (s.mode == MODE_WORD && is_letter(b));
        if (more) begin
          if (s.token_count < 12'(PREFIX_BYTES))
            s.word_prefix = {s.word_prefix[PREFIX_W-9:0], b};
          if (s.token_count < LENGTH_LIMIT) s.token_count = LEN_W'(s.token_count + 1'b1);
          s.current_column = sat_inc_pos(s.current_column);
          handled = 1'b1;
        end else begin
          t[n] = make_token(wk, s.token_line, s.token_column, s.token_count);
          n = NUM_W'(n + 1'b1);
          s.mode = MODE_IDLE;
        end
      end

      // skip a line comment up to the newline
      if (!handled && s.mode == MODE_LINE) begin
        if (b != CH_NEWLINE) begin
          s.current_column = sat_inc_pos(s.current_column);
          handled = 1'b1;
        end else begin
          s.mode = MODE_IDLE;
        end
      end

      // skip a block comment up to ')#'
      if (!handled && s.mode == MODE_BLOCK) begin
        handled = 1'b1;
        if (s.saw_close_paren && b == CH_HASH) begin
          s.mode            = MODE_IDLE;
          s.saw_close_paren = 1'b0;
          s.current_column  = sat_inc_pos(s.current_column);
        end else if (b == CH_NUL) begin
          t[n] = make_token(KIND_UNCLOSED, s.token_line, s.token_column, 12'd0);
          n = NUM_W'(n + 1'b1);
          s.stopped = 1'b1;
        end else begin
          if (b == CH_NEWLINE) begin
            s.current_line   = sat_inc_pos(s.current_line);
            s.current_column = 16'd1;
          end else begin
            s.current_column = sat_inc_pos(s.current_column);
          end
          s.saw_close_paren = (b == CH_RPAREN);
        end
      end

      // start a new token between tokens
      if (!handled) begin
        if (b == CH_SPACE || b == CH_TAB) begin
          s.current_column = sat_inc_pos(s.current_column);
        end else if (b == CH_NEWLINE) begin
          s.current_line   = sat_inc_pos(s.current_line);
          s.current_column = 16'd1;
        end else if (b == CH_NUL) begin
          t[n] = make_token(KIND_END, s.current_line, s.current_column, 12'd0);
          n = NUM_W'(n + 1'b1);
          s.stopped = 1'b1;
        end else if (is_letter(b) || is_digit(b)) begin
          s.mode           = is_digit(b) ? MODE_NUMBER : MODE_WORD;
          s.token_line     = s.current_line;
          s.token_column   = s.current_column;
          s.token_count    = 12'd1;
          s.word_prefix    = {{(PREFIX_W-8){1'b0}}, b};
          s.current_column = sat_inc_pos(s.current_column);
        end else if (b == CH_EQUALS || b == CH_HASH) begin
          s.pending_equals = (b == CH_EQUALS);
          s.pending_hash   = (b == CH_HASH);
          s.token_line     = s.current_line;
          s.token_column   = s.current_column;
          s.current_column = sat_inc_pos(s.current_column);
        end else if (single_kind(b) != KIND_BAD) begin
          t[n] = make_token(single_kind(b), s.current_line, s.current_column, 12'd1);
          n = NUM_W'(n + 1'b1);
          s.current_column = sat_inc_pos(s.current_column);
        end else begin
          t[n] = make_token(KIND_BAD, s.current_line, s.current_column, 12'd0);
          n = NUM_W'(n + 1'b1);
          s.stopped = 1'b1;
        end
      end

      // flush held work at the end of the stream
      if (end_of_source && !s.stopped) begin
        if (s.pending_equals) begin
          t[n] = make_token(KIND_ASSIGN, s.token_line, s.token_column, 12'd1);
          n = NUM_W'(n + 1'b1);
        end else if (s.mode == MODE_WORD || s.mode == MODE_NUMBER) begin
          // word kind from the state reached by this byte
          if (s.mode == MODE_NUMBER) begin
            wk = KIND_INT;
          end else if (s.token_count == 12'd3 && s.word_prefix == WORD_DEF) begin
            wk = KIND_DEF;
          end else if (s.token_count == 12'd2 && s.word_prefix == WORD_FN) begin
            wk = KIND_FN;
          end else if (s.token_count == 12'd6 && s.word_prefix == WORD_MODULE) begin
            wk = KIND_MODULE;
          end else begin
            wk = KIND_IDENT;
          end
          if (n < NUM_W'(MAX_RESULTS)) begin
            t[n] = make_token(wk, s.token_line, s.token_column, s.token_count);
            n = NUM_W'(n + 1'b1);
          end
        end
        if (n < NUM_W'(MAX_RESULTS)) begin
          if (s.mode == MODE_BLOCK && !s.pending_equals)
            t[n] = make_token(KIND_UNCLOSED, s.token_line, s.token_column, 12'd0);
          else
            t[n] = make_token(KIND_END, s.current_line, s.current_column, 12'd0);
          n = NUM_W'(n + 1'b1);
        end
      end

      if (end_of_source) s = STATE_RESET;
    end

    // mark the final token of this byte
    if (n != '0) t[NUM_W'(n - 1'b1)].last = 1'b1;

    state_next = s;
    toks       = t;
    num_toks   = n;
  end

endmodule

FILE: hdl/sct_token_fifo.sv
// ----------------------------------------------------------------------------
// Source character tokenizer token queue
// Four-word queue taking up to three tokens per cycle while it has room, one out per cycle while ready is high.
// ----------------------------------------------------------------------------
`include "source_character_tokenizer_macros.svh"

module sct_token_fifo
  import sct_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  token_t           push_toks [MAX_RESULTS],
  input  logic [NUM_W-1:0] push_num,
  output logic             room,
  sct_token_if.source      tokens
);

  token_t           mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop  = tokens.valid && tokens.ready;
  assign room = (count <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));

  // Write the new tokens in order
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (NUM_W'(i) < push_num) mem[PTR_W'(wr_ptr + PTR_W'(i))] <= push_toks[i];
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + PTR_W'(push_num));
      rd_ptr <= PTR_W'(rd_ptr + PTR_W'(pop));
      count  <= CNT_W'(count + CNT_W'(push_num) - CNT_W'(pop));
    end
  end

  // Present the oldest word
  assign tokens.valid        = (count != '0);
  assign tokens.token_kind   = mem[rd_ptr].kind;
  assign tokens.start_line   = mem[rd_ptr].line;
  assign tokens.start_column = mem[rd_ptr].column;
  assign tokens.token_length = mem[rd_ptr].length;
  assign tokens.last_of_run  = mem[rd_ptr].last;

  `SCT_ASSERT(a_no_overflow, (push_num != '0) |-> (count + CNT_W'(push_num) - CNT_W'(pop) <= CNT_W'(FIFO_DEPTH)), "token queue overflow")
  `SCT_ASSERT_ALWAYS(a_empty_after_reset, $past(rst) |-> (count == '0), "token queue not empty after reset")

endmodule

FILE: tb/source_character_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// Source character tokenizer testbench
// Streams source text into the tokenizer and checks every token it returns.
// A scoreboard class lexes each accepted byte the same way the block should,
// queues the tokens that byte must cause and compares each delivered token
// against the oldest one waiting. Stimulus is a directed set of corner
// streams, then random streams built mostly from well-formed pieces.
// ----------------------------------------------------------------------------
module source_character_tokenizer_tb;
  import sct_pkg::*;

  // Lexer mirror and the queue of tokens still owed by the block
  class token_scoreboard;
    mode_t             mode;
    bit                eq_held;
    bit                hash_held;
    bit                close_seen;
    bit                halted;
    logic [POS_W-1:0]  cur_line;
    logic [POS_W-1:0]  cur_col;
    logic [POS_W-1:0]  tok_line;
    logic [POS_W-1:0]  tok_col;
    logic [LEN_W-1:0]  tok_len;
    logic [PREFIX_W-1:0] prefix;
    token_t            awaited_tokens[$];
    int                failures;
    int                checked;

    function new();
      failures = 0;
      checked  = 0;
      restart();
    endfunction

    function void restart();
      mode       = MODE_IDLE;
      eq_held    = 1'b0;
      hash_held  = 1'b0;
      close_seen = 1'b0;
      halted     = 1'b0;
      cur_line   = 16'd1;
      cur_col    = 16'd1;
      tok_line   = 16'd1;
      tok_col    = 16'd1;
      tok_len    = '0;
      prefix     = '0;
    endfunction

    function bit letter(logic [7:0] b);
      return b == CH_UNDER || (b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
             (b >= CH_UPPER_A && b <= CH_UPPER_Z);
    endfunction

    function bit digit(logic [7:0] b);
      return b >= CH_DIGIT0 && b <= CH_DIGIT9;
    endfunction

    function kind_t op_kind(logic [7:0] b);
      case (b)
        CH_COLON:  return KIND_COLON;
        CH_LPAREN: return KIND_LPAREN;
        CH_RPAREN: return KIND_RPAREN;
        CH_SEMI:   return KIND_SEMI;
        CH_LBRACE: return KIND_LBRACE;
        CH_RBRACE: return KIND_RBRACE;
        CH_PLUS:   return KIND_PLUS;
        CH_MINUS:  return KIND_MINUS;
        CH_SLASH:  return KIND_SLASH;
        CH_STAR:   return KIND_STAR;
        CH_CARET:  return KIND_CARET;
        CH_COMMA:  return KIND_COMMA;
        default:   return KIND_BAD;
      endcase
    endfunction

    function void advance_col();
      if (cur_col != POSITION_LIMIT) cur_col = cur_col + 16'd1;
    endfunction

    function void next_line();
      if (cur_line != POSITION_LIMIT) cur_line = cur_line + 16'd1;
      cur_col = 16'd1;
    endfunction

    function void mark_start();
      tok_line = cur_line;
      tok_col  = cur_col;
    endfunction

    function void owe(kind_t k, logic [POS_W-1:0] l, logic [POS_W-1:0] c,
                      logic [LEN_W-1:0] n);
      token_t t;
      t.kind   = k;
      t.line   = l;
      t.column = c;
      t.length = n;
      t.last   = 1'b0;
      awaited_tokens.push_back(t);
    endfunction

    // Close the word or number in progress
    function void owe_word();
      kind_t k;
      k = KIND_INT;
      if (mode == MODE_WORD) begin
        k = KIND_IDENT;
        if (tok_len == 3 && prefix == WORD_DEF) k = KIND_DEF;
        if (tok_len == 2 && prefix == WORD_FN) k = KIND_FN;
        if (tok_len == 6 && prefix == WORD_MODULE) k = KIND_MODULE;
      end
      owe(k, tok_line, tok_col, tok_len);
    endfunction

    // Lex one accepted byte and queue the tokens it causes
    function void take_byte(logic [7:0] b, logic eos);
      bit     done;
      kind_t  k;
      int     base;
      token_t t;
      done = 1'b0;
      base = awaited_tokens.size();
      if (halted) begin
        if (eos) restart();
        return;
      end

      // Resolve a held '=' or '#'
      if (eq_held) begin
        eq_held = 1'b0;
        if (b == CH_GREATER) begin
          owe(KIND_ARROW, tok_line, tok_col, 12'd2);
          advance_col();
          done = 1'b1;
        end else begin
          owe(KIND_ASSIGN, tok_line, tok_col, 12'd1);
        end
      end
      if (hash_held) begin
        hash_held  = 1'b0;
        mode       = (b == CH_LPAREN) ? MODE_BLOCK : MODE_LINE;
        close_seen = 1'b0;
      end

      // Extend or close a word or number
      if (!done && (mode == MODE_WORD || mode == MODE_NUMBER)) begin
        if (digit(b) || (mode == MODE_WORD && letter(b))) begin
          if (tok_len < 6) prefix = {prefix[PREFIX_W-9:0], b};
          if (tok_len != LENGTH_LIMIT) tok_len = tok_len + 12'd1;
          advance_col();
          done = 1'b1;
        end else begin
          owe_word();
          mode = MODE_IDLE;
        end
      end

      // Skip line comment text
      if (!done && mode == MODE_LINE) begin
        if (b != CH_NEWLINE) begin
          advance_col();
          done = 1'b1;
        end else begin
          mode = MODE_IDLE;
        end
      end

      // Skip block comment text, watch for the closing pair
      if (!done && mode == MODE_BLOCK) begin
        done = 1'b1;
        if (close_seen && b == CH_HASH) begin
          mode       = MODE_IDLE;
          close_seen = 1'b0;
          advance_col();
        end else if (b == CH_NUL) begin
          owe(KIND_UNCLOSED, tok_line, tok_col, 12'd0);
          halted = 1'b1;
        end else begin
          if (b == CH_NEWLINE) next_line();
          else advance_col();
          close_seen = (b == CH_RPAREN);
        end
      end

      // Start something new between tokens
      if (!done) begin
        if (b == CH_SPACE || b == CH_TAB) begin
          advance_col();
        end else if (b == CH_NEWLINE) begin
          next_line();
        end else if (b == CH_NUL) begin
          owe(KIND_END, cur_line, cur_col, 12'd0);
          halted = 1'b1;
        end else if (letter(b) || digit(b)) begin
          mode    = digit(b) ? MODE_NUMBER : MODE_WORD;
          mark_start();
          tok_len = 12'd1;
          prefix  = {40'd0, b};
          advance_col();
        end else if (b == CH_EQUALS) begin
          eq_held = 1'b1;
          mark_start();
          advance_col();
        end else if (b == CH_HASH) begin
          hash_held = 1'b1;
          mark_start();
          advance_col();
        end else begin
          k = op_kind(b);
          if (k != KIND_BAD) begin
            owe(k, cur_line, cur_col, 12'd1);
            advance_col();
          end else begin
            owe(KIND_BAD, cur_line, cur_col, 12'd0);
            halted = 1'b1;
          end
        end
      end

      // Flush at the end of the source
      if (eos && !halted) begin
        if (eq_held) begin
          owe(KIND_ASSIGN, tok_line, tok_col, 12'd1);
          owe(KIND_END, cur_line, cur_col, 12'd0);
        end else if (mode == MODE_WORD || mode == MODE_NUMBER) begin
          owe_word();
          owe(KIND_END, cur_line, cur_col, 12'd0);
        end else if (mode == MODE_BLOCK) begin
          owe(KIND_UNCLOSED, tok_line, tok_col, 12'd0);
        end else begin
          owe(KIND_END, cur_line, cur_col, 12'd0);
        end
      end
      if (eos) restart();

      // Flag the final token of this byte
      if (awaited_tokens.size() > base) begin
        t = awaited_tokens.pop_back();
        t.last = 1'b1;
        awaited_tokens.push_back(t);
      end
    endfunction

    function void report(string what, token_t want, token_t got);
      failures++;
      if (failures <= 10) begin
        $write("token %0d %s: expected kind %0d line %0d col %0d len %0d last %0d",
               checked, what, want.kind, want.line, want.column, want.length, want.last);
        $display(", got kind %0d line %0d col %0d len %0d last %0d",
                 got.kind, got.line, got.column, got.length, got.last);
      end
    endfunction

    // Compare a delivered token with the oldest one owed
    function void check_token(token_t got);
      token_t want;
      want = '0;
      if (awaited_tokens.size() == 0) begin
        report("unexpected", want, got);
      end else begin
        want = awaited_tokens.pop_front();
        if (got.kind !== want.kind || got.line !== want.line ||
            got.column !== want.column || got.length !== want.length ||
            got.last !== want.last)
          report("mismatch", want, got);
      end
      checked++;
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   src_gaps;
  bit   sink_stalls;
  logic [7:0] src_text[$];
  token_scoreboard sb;

  sct_byte_if  byte_ch();
  sct_token_if token_ch();

  source_character_tokenizer DUT (
    .clk    (clk),
    .rst    (rst),
    .chars  (byte_ch),
    .tokens (token_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the token side at random while stalls are enabled
  always @(negedge clk) begin
    token_ch.ready <= sink_stalls ? ($urandom_range(0, 99) >= 36) : 1'b1;
  end

  // Check every token word taken
  always @(posedge clk) begin : sample_tokens
    token_t seen;
    if (!rst && token_ch.valid && token_ch.ready) begin
      seen.kind   = kind_t'(token_ch.token_kind);
      seen.line   = token_ch.start_line;
      seen.column = token_ch.start_column;
      seen.length = token_ch.token_length;
      seen.last   = token_ch.last_of_run;
      sb.check_token(seen);
    end
  end

  // Offer one byte word, starting and ending at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (src_gaps && $urandom_range(0, 99) < 36) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.source_byte   <= b;
    byte_ch.end_of_source <= eos;
    do @(posedge clk); while (!byte_ch.ready);
    sb.take_byte(b, eos);
    @(negedge clk);
  endtask

  // Send the built text as one source, marking its last byte
  task automatic send_stream();
    foreach (src_text[i]) send_byte(src_text[i], i == src_text.size() - 1);
    src_text.delete();
  endtask

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
  endfunction

  function logic [7:0] pick(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // Append one random piece of source text
  function void add_piece();
    int sel;
    int n;
    logic [7:0] b;
    sel = $urandom_range(0, 19);
    case (sel)
      0, 1, 2, 3: begin
        src_text.push_back(pick("_abcdefmnozAFMZ"));
        n = $urandom_range(0, 7);
        repeat (n) src_text.push_back(pick("_adefmnoluzAZ09"));
      end
      4: begin
        case ($urandom_range(0, 5))
          0: add_text("def");
          1: add_text("fn");
          2: add_text("module");
          3: add_text("de");
          4: add_text("modules");
          default: add_text("fn_");
        endcase
      end
      5, 6: begin
        n = $urandom_range(1, 6);
        repeat (n) src_text.push_back(pick("0123456789"));
      end
      7, 8, 9: src_text.push_back(pick(":();{}+-/*^,"));
      10: begin
        if ($urandom_range(0, 1)) add_text("=>");
        else add_text("=");
      end
      13: src_text.push_back(CH_NEWLINE);
      14: begin
        src_text.push_back(CH_HASH);
        n = $urandom_range(0, 6);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_NEWLINE) b = CH_LOWER_A;
          src_text.push_back(b);
        end
        if ($urandom_range(0, 3) != 0) src_text.push_back(CH_NEWLINE);
      end
      15: begin
        add_text("#(");
        n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_NUL && $urandom_range(0, 9) != 0) b = CH_SPACE;
          end else begin
            b = pick(")#(\n a");
          end
          src_text.push_back(b);
        end
        add_text(")#");
      end
      16: begin
        if ($urandom_range(0, 1)) src_text.push_back(8'($urandom_range(0, 255)));
        else src_text.push_back(CH_SPACE);
      end
      default: src_text.push_back(pick("  \t"));
    endcase
  endfunction

  // Build a random source, usually ending on its last piece
  function void make_random_stream();
    int target;
    int n;
    target = $urandom_range(4, 40);
    while (src_text.size() < target) add_piece();
    case ($urandom_range(0, 9))
      0: begin
        src_text.push_back(CH_NUL);
        n = $urandom_range(1, 3);
        repeat (n) src_text.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        add_text("#(");
        if ($urandom_range(0, 1)) src_text.push_back(pick(")a\n"));
      end
      default: ;
    endcase
  endfunction

  initial begin
    int random_bytes;
    int stream_no;
    sb = new();
    rst = 1'b1;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.source_byte = 8'h00;
    byte_ch.end_of_source = 1'b0;
    token_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sb.restart();

    // Keywords, arrow, tab, '=' before a digit, number flushed at the end
    add_text("def fn=>x\t=1");
    send_stream();
    // Block comment over a newline, zero byte end, ignored tail
    add_text("module#(\n)#");
    src_text.push_back(CH_NUL);
    add_text("!");
    send_stream();
    // Zero byte inside a line comment, lone '>' as bad char
    add_text("#");
    src_text.push_back(CH_NUL);
    add_text("\n>");
    src_text.push_back(8'hFF);
    send_stream();
    // Zero byte inside a block comment
    add_text("#(");
    src_text.push_back(CH_NUL);
    add_text("a");
    send_stream();
    // Held '=', open block comment and '#' as final bytes
    add_text("=");
    send_stream();
    add_text("#(");
    send_stream();
    add_text("#");
    send_stream();
    // Carriage return and a high byte are bad chars
    src_text.push_back(8'h0D);
    send_stream();
    src_text.push_back(8'h80);
    send_stream();
    add_text("7");
    send_stream();

    // Random streams, with a stretch of no idling in the middle
    random_bytes = 0;
    stream_no = 0;
    while (random_bytes < 440) begin
      src_gaps    = !(stream_no >= 8 && stream_no < 16);
      sink_stalls = src_gaps;
      make_random_stream();
      random_bytes += src_text.size();
      send_stream();
      stream_no++;
    end
    byte_ch.valid <= 1'b0;
    sink_stalls = 1'b1;

    // Drain and let the pipeline settle
    while (sb.awaited_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #10000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/sct_pkg.sv
hdl/sct_if.sv
hdl/sct_step.sv
hdl/sct_token_fifo.sv
hdl/source_character_tokenizer.sv
tb/source_character_tokenizer_tb.sv
